// ===== hw/rtl/dfhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfhc_pkg - shared types and constants for the frame header checker
// Header field positions, error codes, result and queue types used by the
// register block, the parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package dfhc_pkg;

    // Data path widths
    localparam int WORD_W      = 64;
    localparam int SIZE_W      = 15;
    localparam int FNUM_W      = 36;
    localparam int EVCNT_W     = 16;
    localparam int TYPE_W      = 3;
    localparam int ERR_W       = 2;

    // Header word 0 layout
    localparam int TYPE_LSB    = 51;
    localparam int SIZE_LSB    = 36;
    localparam int FNUM_LSB    = 0;
    // Header word 1 layout
    localparam int EVCNT_LSB   = 0;
    localparam int LOST_BIT    = 16;

    localparam logic [TYPE_W-1:0] FRAME_TYPE_DATA = 3'd1;
    localparam logic [SIZE_W-1:0] HEADER_WORDS    = 15'd2;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_WORDS = 1'b0;
    localparam logic [SIZE_W-1:0]    MAX_WORDS_RESET     = 15'd16384;

    // Error codes carried with each result
    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_BAD_TYPE = 2'd1,
        ERR_TOO_BIG  = 2'd2,
        ERR_SIZE_MIS = 2'd3
    } t_err;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               first;
        logic               last;
        logic [FNUM_W-1:0]  frame_number;
        logic [EVCNT_W-1:0] event_count;
        logic               lost;
        t_err               err;
    } t_result;

    // Results pushed by the parser in one cycle
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    // Queue status towards the parser
    typedef struct packed {
        logic               room_two;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

// ===== hw/rtl/dfhc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dfhc_cfg_regs - configuration register block
// APB-style slave holding the maximum frame size register.
// ----------------------------------------------------------------------------
module dfhc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dfhc_pkg::PADDR_W-1:0] paddr,
    input  logic [dfhc_pkg::PDATA_W-1:0] pwdata,
    output logic [dfhc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [dfhc_pkg::SIZE_W-1:0]  o_max_frame_words
);
    import dfhc_pkg::*;

    logic [SIZE_W-1:0]    r_max_frame_words;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode register index from the byte address
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAX_FRAME_WORDS);
    assign pready  = 1'b1;

    // Write the register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_words <= MAX_WORDS_RESET;
        end else if (wr_en) begin
            r_max_frame_words <= pwdata[SIZE_W-1:0];
        end
    end

    // Read back, zero for unmapped addresses
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_MAX_FRAME_WORDS) begin
            prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_max_frame_words};
        end
    end

    assign o_max_frame_words = r_max_frame_words;

endmodule

// ===== hw/rtl/dfhc_parser.sv =====
// ----------------------------------------------------------------------------
// dfhc_parser - input register and frame header state machine
// Registers each input word, checks the two-word header and produces up to
// two results per word for the result queue.
// ----------------------------------------------------------------------------
module dfhc_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dfhc_pkg::WORD_W-1:0] i_data_word,
    input  logic                        i_buffer_end,
    input  logic [dfhc_pkg::SIZE_W-1:0] i_max_frame_words,
    input  dfhc_pkg::t_q_status         i_q_status,
    output dfhc_pkg::t_push             o_push
);
    import dfhc_pkg::*;

    typedef enum logic [3:0] {
        PH_HEAD0   = 4'b0001,
        PH_HEAD1   = 4'b0010,
        PH_FORWARD = 4'b0100,
        PH_DISCARD = 4'b1000
    } t_phase;

    // Input register
    logic               r_in_valid;
    logic [WORD_W-1:0]  r_in_word;
    logic               r_in_end;
    // Frame state
    t_phase             r_phase,        n_phase;
    logic [WORD_W-1:0]  r_held,         n_held;
    logic [SIZE_W-1:0]  r_words_left,   n_words_left;
    logic [FNUM_W-1:0]  r_cur_fnum,     n_cur_fnum;
    logic [EVCNT_W-1:0] r_cur_evcnt,    n_cur_evcnt;
    logic               r_cur_lost,     n_cur_lost;

    logic               advance;
    logic               accept;
    logic [TYPE_W-1:0]  hdr_type;
    logic [SIZE_W-1:0]  hdr_size;
    logic [FNUM_W-1:0]  hdr_fnum;
    logic [EVCNT_W-1:0] hdr_evcnt;
    logic               hdr_lost;
    logic [SIZE_W+1:0]  evcnt_plus;
    t_err               hdr_err;

    // Process the held word only when the queue can take two results
    assign advance = r_in_valid && i_q_status.room_two;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_data_word;
            r_in_end  <= i_buffer_end;
        end
    end

    // Decode header fields
    assign hdr_type   = r_held[TYPE_LSB +: TYPE_W];
    assign hdr_size   = r_held[SIZE_LSB +: SIZE_W];
    assign hdr_fnum   = r_held[FNUM_LSB +: FNUM_W];
    assign hdr_evcnt  = r_in_word[EVCNT_LSB +: EVCNT_W];
    assign hdr_lost   = r_in_word[LOST_BIT];
    assign evcnt_plus = {1'b0, hdr_evcnt} + {2'b00, HEADER_WORDS};

    // Check header in priority order, first failure wins
    always_comb begin
        priority if (hdr_type != FRAME_TYPE_DATA) begin
            hdr_err = ERR_BAD_TYPE;
        end else if (hdr_size > i_max_frame_words) begin
            hdr_err = ERR_TOO_BIG;
        end else if ({2'b00, hdr_size} != evcnt_plus) begin
            hdr_err = ERR_SIZE_MIS;
        end else begin
            hdr_err = ERR_OK;
        end
    end

    // Next state and results
    always_comb begin
        n_phase      = r_phase;
        n_held       = r_held;
        n_words_left = r_words_left;
        n_cur_fnum   = r_cur_fnum;
        n_cur_evcnt  = r_cur_evcnt;
        n_cur_lost   = r_cur_lost;
        o_push       = '0;
        o_push.res0.frame_number = r_cur_fnum;
        o_push.res0.event_count  = r_cur_evcnt;
        o_push.res0.lost         = r_cur_lost;
        o_push.res0.err          = ERR_OK;
        o_push.res1              = o_push.res0;
        if (advance) begin
            unique case (r_phase)
                PH_HEAD0: begin
                    n_held  = r_in_word;
                    n_phase = PH_HEAD1;
                end
                PH_HEAD1: begin
                    n_cur_fnum  = hdr_fnum;
                    n_cur_evcnt = hdr_evcnt;
                    n_cur_lost  = hdr_lost;
                    o_push.res0.frame_number = hdr_fnum;
                    o_push.res0.event_count  = hdr_evcnt;
                    o_push.res0.lost         = hdr_lost;
                    o_push.res1              = o_push.res0;
                    o_push.push0             = 1'b1;
                    if (hdr_err != ERR_OK) begin
                        o_push.res0.err = hdr_err;
                        n_phase         = PH_DISCARD;
                    end else begin
                        o_push.res0.word  = r_held;
                        o_push.res0.first = 1'b1;
                        o_push.push1      = 1'b1;
                        o_push.res1.word  = r_in_word;
                        o_push.res1.last  = (hdr_size == HEADER_WORDS);
                        n_words_left      = hdr_size - HEADER_WORDS;
                        n_phase = (hdr_size == HEADER_WORDS) ? PH_HEAD0 : PH_FORWARD;
                    end
                end
                PH_FORWARD: begin
                    o_push.push0     = 1'b1;
                    o_push.res0.word = r_in_word;
                    o_push.res0.last = (r_words_left == SIZE_W'(1));
                    n_words_left     = r_words_left - SIZE_W'(1);
                    if (r_words_left == SIZE_W'(1)) begin
                        n_phase = PH_HEAD0;
                    end
                end
                PH_DISCARD: begin
                    n_phase = PH_DISCARD;
                end
                default: begin
                    n_phase = PH_HEAD0;
                end
            endcase
            // Buffer end always restarts header search
            if (r_in_end) begin
                n_phase = PH_HEAD0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEAD0;
            r_held       <= '0;
            r_words_left <= '0;
            r_cur_fnum   <= '0;
            r_cur_evcnt  <= '0;
            r_cur_lost   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_words_left <= n_words_left;
            r_cur_fnum   <= n_cur_fnum;
            r_cur_evcnt  <= n_cur_evcnt;
            r_cur_lost   <= n_cur_lost;
        end
    end

endmodule

// ===== hw/rtl/dfhc_result_queue.sv =====
// ----------------------------------------------------------------------------
// dfhc_result_queue - small result buffer
// Takes up to two results per cycle and hands one per transaction to the
// output channel.
// ----------------------------------------------------------------------------
module dfhc_result_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dfhc_pkg::t_push       i_push,
    input  logic                  i_stall,
    output logic                  o_valid,
    output dfhc_pkg::t_result     o_result,
    output dfhc_pkg::t_q_status   o_status
);
    import dfhc_pkg::*;

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;
    logic [Q_CNT_W-1:0] n_push;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_mem[r_rd_ptr];
    assign n_push   = Q_CNT_W'(i_push.push0) + Q_CNT_W'(i_push.push1);

    assign o_status.count    = r_count;
    assign o_status.room_two = (r_count <= Q_CNT_W'(Q_DEPTH - 2));

    // Store pushed results in order
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + Q_PTR_W'(1)] <= i_push.res1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + n_push[Q_PTR_W-1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + n_push - Q_CNT_W'(pop);
        end
    end

endmodule

// ===== hw/rtl/daq_frame_header_checker.sv =====
// ----------------------------------------------------------------------------
// daq_frame_header_checker - DMA frame header checker
// Checks two-word frame headers in a stream of buffer words and forwards
// valid frames with first/last marks, or one error result per bad header.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_data_word, i_buffer_end
//   output   out        o_valid / i_stall   o_out_word .. o_error_code
//   config   in         psel/penable/pready max_frame_words at address 0
//
// One word per cycle is taken while o_stall is low; a word passes through
// the input register and then the result queue on its way to the output.
// The second word of a good header yields two results; a four-entry result
// queue absorbs them, and input stalls while fewer than two entries are free.
// Reset is synchronous and clears the frame state and the queue.
// Output stall backs up through the queue to the input register.
// ----------------------------------------------------------------------------
module daq_frame_header_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dfhc_pkg::WORD_W-1:0]  i_data_word,
    input  logic                         i_buffer_end,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dfhc_pkg::WORD_W-1:0]  o_out_word,
    output logic                         o_frame_first,
    output logic                         o_frame_last,
    output logic [dfhc_pkg::FNUM_W-1:0]  o_frame_number,
    output logic [dfhc_pkg::EVCNT_W-1:0] o_event_count,
    output logic                         o_lost_flag,
    output logic [dfhc_pkg::ERR_W-1:0]   o_error_code,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dfhc_pkg::PADDR_W-1:0] paddr,
    input  logic [dfhc_pkg::PDATA_W-1:0] pwdata,
    output logic [dfhc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import dfhc_pkg::*;

    logic [SIZE_W-1:0] max_frame_words;
    t_push             push;
    t_q_status         q_status;
    t_result           result;

    // Configuration registers
    dfhc_cfg_regs u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_max_frame_words (max_frame_words)
    );

    // Header check and forwarding
    dfhc_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_word       (i_data_word),
        .i_buffer_end      (i_buffer_end),
        .i_max_frame_words (max_frame_words),
        .i_q_status        (q_status),
        .o_push            (push)
    );

    // Result buffering
    dfhc_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (result),
        .o_status (q_status)
    );

    assign o_out_word     = result.word;
    assign o_frame_first  = result.first;
    assign o_frame_last   = result.last;
    assign o_frame_number = result.frame_number;
    assign o_event_count  = result.event_count;
    assign o_lost_flag    = result.lost;
    assign o_error_code   = result.err;

    // Queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // Pushes only happen with room for two results
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push0 |-> q_status.room_two)
        else $error("result pushed without room");

    // Error results carry no word and no frame marks
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != ERR_OK)) |->
            ((o_out_word == '0) && !o_frame_first && !o_frame_last))
        else $error("error result carries frame data");

    // A frame start is never also its end
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_first) |-> !o_frame_last)
        else $error("first header word marked last");

endmodule
